### sv/itoa_pkg.sv
// Package: widths, mode codes, ASCII codes and control types of the integer to ASCII converter.
`default_nettype none
package itoa_pkg;

	// Width of the converted value
	localparam int VALUE_WIDTH = 64;

	// Decimal digits needed for 2^VALUE_WIDTH - 1 (1233/4096 approximates log10(2))
	localparam int DIG_N = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int BCD_W = 4 * DIG_N;

	// Counter widths
	localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_CNT_W = $clog2(DIG_N + 1);

	// Mode codes
	localparam logic [1:0] OP_SIGNED   = 2'd0;
	localparam logic [1:0] OP_UNSIGNED = 2'd1;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_A_OFS = 8'h57;

	// Controls from the sequencer to the digit register
	typedef struct packed {
		logic load;
		logic hex;
		logic step;
		logic shift;
	} dab_ctl_t;

	// Map one digit to its lower-case ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] ext;
		ext = {4'h0, d};
		if (d < 4'd10) begin
			digit_char = CHAR_ZERO + ext;
		end else begin
			digit_char = CHAR_A_OFS + ext;
		end
	endfunction

endpackage
`default_nettype wire

### sv/itoa_dabble.sv
// Bit-serial double dabble digit register with a nibble shift-out for emission.
`default_nettype none
module itoa_dabble
	import itoa_pkg::*;
(
	input  wire logic                   clk,
	input  wire dab_ctl_t               ctl,
	input  wire logic [VALUE_WIDTH-1:0] mag,
	output logic [3:0]                  top_digit
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;
	logic [BCD_W-1:0]       hex_load;

	// Add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Place hex nibbles straight into the digit register
	always_comb begin
		hex_load = '0;
		hex_load[VALUE_WIDTH-1:0] = mag;
	end

	// Load, shift in one magnitude bit, or shift out one digit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mag_q <= mag;
			bcd_q <= ctl.hex ? hex_load : '0;
		end else if (ctl.step) begin
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end else if (ctl.shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'h0};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule
`default_nettype wire

### sv/integer_to_ascii_converter.sv
// Top level: converts a value to signed decimal, unsigned decimal or hex ASCII text.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    op, value
//   output   out        out_valid / out_ready  ascii_char, last_char
//
// A request passes through a load, the bit-serial double dabble over VALUE_WIDTH bits
// (skipped in hex mode), the prefix characters, the skip of leading zeros and the digits.
// The shift register of the digit unit takes one bit in a cycle, and gives one digit
// out a cycle while the output is not stalled. Reset needs no clearing pass. A stalled
// output holds the sequencer; a new request is taken once the last character sits in
// the output register.
`default_nettype none
module integer_to_ascii_converter
	import itoa_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             op,
	input  wire logic [63:0]            value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  ascii_char,
	output logic                        last_char
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_PRE  = 3'd2;
	localparam logic [2:0] ST_SKIP = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]             state_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic [1:0]             pre_left_q;
	logic                   hex_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	logic                   accept;
	logic                   out_free;
	logic [VALUE_WIDTH-1:0] v;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic [3:0]             top_digit;
	logic                   load_out;
	logic [7:0]             load_char;
	logic                   load_last;
	dab_ctl_t               ctl;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Take the magnitude of the request
	assign v   = value[VALUE_WIDTH-1:0];
	assign neg = (op == OP_SIGNED) && v[VALUE_WIDTH-1];
	assign mag = neg ? (~v + 1'b1) : v;

	// Drive the digit unit and the output register
	always_comb begin
		ctl       = '0;
		ctl.load  = accept;
		ctl.hex   = op[1];
		load_out  = 1'b0;
		load_char = digit_char(top_digit);
		load_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_CONV: begin
				ctl.step = 1'b1;
			end
			ST_PRE: begin
				load_out = (pre_left_q != 2'd0) && out_free;
				if (!hex_q) begin
					load_char = CHAR_MINUS;
				end else if (pre_left_q == 2'd2) begin
					load_char = CHAR_ZERO;
				end else begin
					load_char = CHAR_X;
				end
			end
			ST_SKIP: begin
				ctl.shift = (top_digit == 4'h0) && (dig_cnt_q > DIG_CNT_W'(1));
			end
			ST_EMIT: begin
				load_out  = out_free;
				load_last = (dig_cnt_q == DIG_CNT_W'(1));
				ctl.shift = out_free;
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			dig_cnt_q  <= '0;
			pre_left_q <= '0;
			hex_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hex_q     <= op[1];
						bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH);
						dig_cnt_q <= DIG_CNT_W'(DIG_N);
						if (op[1]) begin
							pre_left_q <= 2'd2;
							state_q    <= ST_PRE;
						end else begin
							pre_left_q <= neg ? 2'd1 : 2'd0;
							state_q    <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == BIT_CNT_W'(1)) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					if (pre_left_q == 2'd0) begin
						state_q <= ST_SKIP;
					end else if (out_free) begin
						pre_left_q <= pre_left_q - 1'b1;
					end
				end
				ST_SKIP: begin
					if (ctl.shift) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
						if (load_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold or drop the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the character payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= load_char;
			last_q <= load_last;
		end
	end

	itoa_dabble u_dabble (
		.clk       (clk),
		.ctl       (ctl),
		.mag       (mag),
		.top_digit (top_digit)
	);

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

endmodule
`default_nettype wire

### sv/itoa_checker.sv
// Checker on the ports of the integer to ASCII converter, with its bind statement.
`default_nettype none
module itoa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  op,
	input wire logic [63:0] value,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  ascii_char,
	input wire logic        last_char
);

	// Hold a stalled output character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(last_char))
		else $error("stalled output character changed");

	// Drop ready after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a request");

	// Emit only digits, lower-case hex letters, minus and x
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ascii_char >= 8'h30 && ascii_char <= 8'h39) ||
			(ascii_char >= 8'h61 && ascii_char <= 8'h66) ||
			ascii_char == 8'h2d || ascii_char == 8'h78)
		else $error("character outside the output alphabet");

	// Keep the input closed while the text is unfinished
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |-> !in_ready)
		else $error("request taken before the last character");

endmodule

bind integer_to_ascii_converter itoa_checker u_itoa_checker (.*);
`default_nettype wire
